### src/ttcb_pkg.sv
// shared types and constants for the text terminal character buffer
// no dependencies; compile first
`default_nettype none

package ttcb_pkg;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int TGT_W  = 8;
    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MOVE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SCRL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_BLANK    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;

    // decoded command and cursor outcome for one transaction
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             put;
        logic             scroll;
        logic             clear;
        logic             read;
    } t_cur_res;

endpackage

`default_nettype wire

### src/ttcb_if.sv
// valid/ready channel interfaces for commands and results
// depends on ttcb_pkg
`default_nettype none

interface ttcb_in_if;
    logic                         valid;
    logic                         ready;
    logic [ttcb_pkg::MODE_W-1:0]  mode;
    logic [ttcb_pkg::CHAR_W-1:0]  char_code;
    logic [ttcb_pkg::TGT_W-1:0]   row_target;
    logic [ttcb_pkg::TGT_W-1:0]   col_target;

    modport source(output valid, mode, char_code, row_target, col_target, input ready);
    modport sink(input valid, mode, char_code, row_target, col_target, output ready);
endinterface

interface ttcb_out_if;
    logic                         valid;
    logic                         ready;
    logic [ttcb_pkg::ROW_W-1:0]   cursor_row_now;
    logic [ttcb_pkg::COL_W-1:0]   cursor_col_now;
    logic [ttcb_pkg::CHAR_W-1:0]  cell_value;
    logic                         did_scroll;

    modport source(output valid, cursor_row_now, cursor_col_now, cell_value, did_scroll,
                   input ready);
    modport sink(input valid, cursor_row_now, cursor_col_now, cell_value, did_scroll,
                 output ready);
endinterface

`default_nettype wire

### src/ttcb_cell_mem.sv
// character cell store: one write port, one registered read port
// no package dependencies
`default_nettype none

module ttcb_cell_mem #(
    parameter int DEPTH = 1920,
    parameter int AW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### src/ttcb_cursor.sv
// command decode and cursor update for one transaction
// depends on ttcb_pkg
`default_nettype none

module ttcb_cursor #(
    parameter int ROWS = 24,
    parameter int COLS = 80
) (
    input  wire logic [ttcb_pkg::MODE_W-1:0] i_mode,
    input  wire logic [ttcb_pkg::CHAR_W-1:0] i_char,
    input  wire logic [ttcb_pkg::TGT_W-1:0]  i_row_tgt,
    input  wire logic [ttcb_pkg::TGT_W-1:0]  i_col_tgt,
    input  wire logic [ttcb_pkg::ROW_W-1:0]  i_row,
    input  wire logic [ttcb_pkg::COL_W-1:0]  i_col,
    output ttcb_pkg::t_cur_res               o_res
);
    import ttcb_pkg::*;

    localparam logic [ROW_W:0]   ROWS_N   = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [TGT_W-1:0] ROWS_T   = TGT_W'(ROWS);
    localparam logic [TGT_W-1:0] COLS_T   = TGT_W'(COLS);

    logic [ROW_W:0]   row_inc;
    logic [TGT_W-1:0] col_inc;
    logic [TGT_W-1:0] tab_col;
    logic             row_tgt_ok;
    logic             col_tgt_ok;
    logic             newline;

    assign row_inc    = {1'b0, i_row} + 1'b1;
    assign col_inc    = {1'b0, i_col} + 1'b1;
    // one spare bit so a tab from the last stop reaches 128
    assign tab_col    = {{1'b0, i_col[COL_W-1:3]} + 5'd1, 3'b000};
    assign row_tgt_ok = i_row_tgt < ROWS_T;
    assign col_tgt_ok = i_col_tgt < COLS_T;

    always_comb begin
        o_res     = '0;
        o_res.row = i_row;
        o_res.col = i_col;
        newline   = 1'b0;

        unique case (i_mode)
            MODE_PUT: begin
                unique case (i_char) inside
                    [CH_PRINT_LO:CH_PRINT_HI]: begin
                        o_res.put = 1'b1;
                        if (col_inc >= COLS_T) begin
                            newline = 1'b1;
                        end else begin
                            o_res.col = col_inc[COL_W-1:0];
                        end
                    end
                    CH_LF: newline = 1'b1;
                    CH_CR: o_res.col = '0;
                    CH_BS: begin
                        if (i_col != '0) begin
                            o_res.col = i_col - 1'b1;
                        end
                    end
                    CH_TAB: begin
                        if (tab_col >= COLS_T) begin
                            newline = 1'b1;
                        end else begin
                            o_res.col = tab_col[COL_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            MODE_MOVE: begin
                if (row_tgt_ok) begin
                    o_res.row = i_row_tgt[ROW_W-1:0];
                end
                if (col_tgt_ok) begin
                    o_res.col = i_col_tgt[COL_W-1:0];
                end
            end
            MODE_CLEAR: begin
                o_res.clear = 1'b1;
                o_res.row   = '0;
                o_res.col   = '0;
            end
            MODE_SCRL: o_res.scroll = 1'b1;
            MODE_READ: o_res.read = row_tgt_ok && col_tgt_ok;
            default: ;
        endcase

        // advance past the bottom row keeps the cursor there and scrolls
        if (newline) begin
            o_res.col = '0;
            if (row_inc >= ROWS_N) begin
                o_res.row    = ROW_LAST;
                o_res.scroll = 1'b1;
            end else begin
                o_res.row = row_inc[ROW_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

### src/text_terminal_char_buffer.sv
// text terminal character buffer: top level with the sweep sequencer
// depends on ttcb_pkg, ttcb_if, ttcb_cell_mem and ttcb_cursor
//
// Commands arrive on i_cmd (valid/ready), one result per command leaves on
// o_res through an output register. A command is taken when the sequencer is
// idle and the output register is empty or being drained in the same cycle.
// Put char, move cursor, undefined modes and out-of-range reads finish in the
// cycle they are accepted: one command per cycle while the output register
// drains, the result showing the cycle after. An in-range cell read steps
// through memory read, capture and result load. Scroll runs the shared sweep
// address unit over the store: it copies the (ROWS-1)*COLS cells up a row,
// blanks the bottom row and posts the result. A put char that runs off the
// bottom row costs the same scroll. Clear blanks ROWS*COLS cells, one per
// cycle, then posts the result. After reset the sequencer sweeps zeros into
// all ROWS*COLS cells and takes no command meanwhile. If the receiver
// stalls, a finished result waits in the output register and no further
// command is taken until it is gone.
`default_nettype none

module text_terminal_char_buffer #(
    parameter int ROWS = 24,
    parameter int COLS = 80
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ttcb_in_if.sink     i_cmd,
    ttcb_out_if.source  o_res
);
    import ttcb_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam logic [AW-1:0] COLS_A    = AW'(COLS);
    localparam logic [AW-1:0] LAST_A    = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_LAST = AW'((ROWS - 1) * COLS - 1);
    localparam logic [AW-1:0] FILL_BASE = AW'((ROWS - 1) * COLS);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RDWAIT  = 3'd1;
    localparam logic [2:0] S_COPY_RD = 3'd2;
    localparam logic [2:0] S_COPY_WR = 3'd3;
    localparam logic [2:0] S_FILL    = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_init, n_init;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CHAR_W-1:0] r_res_val, n_res_val;
    logic              r_res_scr, n_res_scr;
    logic              r_out_valid, n_out_valid;
    logic [ROW_W-1:0]  r_out_row, n_out_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [CHAR_W-1:0] r_out_val, n_out_val;
    logic              r_out_scr, n_out_scr;

    t_cur_res          cur;
    logic              slot_free;
    logic              in_ready;
    logic              accept;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     tgt_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;

    ttcb_cursor #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_cursor (
        .i_mode    (i_cmd.mode),
        .i_char    (i_cmd.char_code),
        .i_row_tgt (i_cmd.row_target),
        .i_col_tgt (i_cmd.col_target),
        .i_row     (r_row),
        .i_col     (r_col),
        .o_res     (cur)
    );

    ttcb_cell_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign slot_free   = !r_out_valid || o_res.ready;
    assign in_ready    = (r_state == S_IDLE) && slot_free;
    assign accept      = i_cmd.valid && in_ready;
    assign i_cmd.ready = in_ready;

    assign cur_addr = AW'(r_row) * COLS_A + AW'(r_col);
    assign tgt_addr = AW'(i_cmd.row_target) * COLS_A + AW'(i_cmd.col_target);

    assign o_res.valid          = r_out_valid;
    assign o_res.cursor_row_now = r_out_row;
    assign o_res.cursor_col_now = r_out_col;
    assign o_res.cell_value     = r_out_val;
    assign o_res.did_scroll     = r_out_scr;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_init      = r_init;
        n_row       = r_row;
        n_col       = r_col;
        n_res_val   = r_res_val;
        n_res_scr   = r_res_scr;
        n_out_valid = r_out_valid;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_val   = r_out_val;
        n_out_scr   = r_out_scr;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = CH_BLANK;
        mem_re      = 1'b0;
        mem_raddr   = r_addr + COLS_A;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_row     = cur.row;
                    n_col     = cur.col;
                    n_res_val = '0;
                    n_res_scr = 1'b0;
                    if (cur.put) begin
                        mem_we    = 1'b1;
                        mem_waddr = cur_addr;
                        mem_wdata = i_cmd.char_code;
                    end
                    if (cur.read) begin
                        mem_re    = 1'b1;
                        mem_raddr = tgt_addr;
                        n_state   = S_RDWAIT;
                    end else if (cur.clear) begin
                        n_addr  = '0;
                        n_state = S_FILL;
                    end else if (cur.scroll) begin
                        n_res_scr = 1'b1;
                        if (ROWS > 1) begin
                            n_addr  = '0;
                            n_state = S_COPY_RD;
                        end else begin
                            n_addr  = FILL_BASE;
                            n_state = S_FILL;
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_row   = cur.row;
                        n_out_col   = cur.col;
                        n_out_val   = '0;
                        n_out_scr   = 1'b0;
                    end
                end
            end
            S_RDWAIT: begin
                n_res_val = mem_rdata;
                n_state   = S_DONE;
            end
            S_COPY_RD: begin
                // fetch the cell one row below the sweep address
                mem_re  = 1'b1;
                n_state = S_COPY_WR;
            end
            S_COPY_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                n_addr    = r_addr + 1'b1;
                n_state   = (r_addr == COPY_LAST) ? S_FILL : S_COPY_RD;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = r_init ? '0 : CH_BLANK;
                n_addr    = r_addr + 1'b1;
                if (r_addr == LAST_A) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_row;
                    n_out_col   = r_col;
                    n_out_val   = r_res_val;
                    n_out_scr   = r_res_scr;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // power-up pass writes zeros through the whole store
            r_state     <= S_FILL;
            r_addr      <= '0;
            r_init      <= 1'b1;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_init      <= n_init;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_val <= n_res_val;
        r_res_scr <= n_res_scr;
        r_out_row <= n_out_row;
        r_out_col <= n_out_col;
        r_out_val <= n_out_val;
        r_out_scr <= n_out_scr;
    end

endmodule

`default_nettype wire
